@@ design/sprite_rle_decoder_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the sprite RLE decoder checkers.
// Each macro expects signals named clk and rst in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef SPRITE_RLE_DECODER_ASSERT_SVH
`define SPRITE_RLE_DECODER_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define SRD_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sprite_rle_decoder: same-cycle check failed");

// Next-cycle implication, ignored while reset is high.
`define SRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sprite_rle_decoder: next-cycle check failed");

// Condition that must hold in the cycle after any reset cycle.
`define SRD_ASSERT_AFTER_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("sprite_rle_decoder: post-reset check failed");

`endif

@@ design/srd_pkg.sv @@
// ---------------------------------------------------------------------------
// srd_pkg
// Widths, codes and controller/datapath interface types of the sprite RLE
// decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package srd_pkg;

  localparam int DATA_W      = 8;
  localparam int DIM_W       = 16;
  localparam int ROW_W       = 8;
  localparam int ADDR_W      = 24;
  localparam int CNT_W       = 5;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int OP_W        = 4;

  localparam int MAX_ROWS_DEFAULT = 200;

  localparam logic [DIM_W-1:0] DEFAULT_WIDTH_RESET  = 16'd320;
  localparam logic [DIM_W-1:0] DEFAULT_HEIGHT_RESET = 16'd200;

  // Row counter saturates here; no pixel is written on this row.
  localparam logic [ROW_W-1:0] ROW_SATURATED = 8'hFF;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_HEIGHT = 1'b1;

  // Command byte type, bits 7..6.
  localparam logic [1:0] TYPE_FILL     = 2'b00;
  localparam logic [1:0] TYPE_LIT      = 2'b01;
  localparam logic [1:0] TYPE_SKIP_LIT = 2'b10;
  localparam logic [1:0] TYPE_EXT      = 2'b11;
  // In the extended type this bit selects a pure skip.
  localparam int SKIP_FLAG_BIT = 5;

  // Datapath operations issued when an item is accepted.
  localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
  localparam logic [OP_W-1:0] OP_HDR0      = 4'd1;
  localparam logic [OP_W-1:0] OP_HDR1      = 4'd2;
  localparam logic [OP_W-1:0] OP_HDR2      = 4'd3;
  localparam logic [OP_W-1:0] OP_HDR3      = 4'd4;
  localparam logic [OP_W-1:0] OP_FINISH    = 4'd5;
  localparam logic [OP_W-1:0] OP_FILL_ZERO = 4'd6;
  localparam logic [OP_W-1:0] OP_FILL_ARM  = 4'd7;
  localparam logic [OP_W-1:0] OP_FILL_RUN  = 4'd8;
  localparam logic [OP_W-1:0] OP_SKIP_LIT  = 4'd9;
  localparam logic [OP_W-1:0] OP_SKIP      = 4'd10;
  localparam logic [OP_W-1:0] OP_LIT_ARM   = 4'd11;
  localparam logic [OP_W-1:0] OP_LIT_PIXEL = 4'd12;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            restart;    // final byte of the stream: back to header
    logic            emit_step;  // one pixel of a write loop
    logic            skip_step;  // one pixel of a skip loop
  } dp_cmd_t;

  typedef struct packed {
    logic cmd_ok;     // a command byte may be decoded
    logic cnt_last;   // the loop is on its final pixel
    logic run_last;   // the literal run is on its final byte
    logic slot_free;  // the output register can take a pixel
  } dp_status_t;

  // Run length of a command byte: bits 5..2 plus one, 1 to 16.
  function automatic logic [CNT_W-1:0] run_count(input logic [DATA_W-1:0] b);
    return {1'b0, b[5:2]} + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

@@ design/srd_ctrl.sv @@
// ---------------------------------------------------------------------------
// srd_ctrl
// Decode-phase state machine: takes stream items, decodes command bytes and
// sequences the pixel write and skip loops of the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module srd_ctrl import srd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_ready,
  input  logic [DATA_W-1:0] data_byte,
  input  logic              last_byte,
  output dp_cmd_t           cmd,
  input  dp_status_t        status
);

  localparam logic [3:0] S_HDR0 = 4'd0;
  localparam logic [3:0] S_HDR1 = 4'd1;
  localparam logic [3:0] S_HDR2 = 4'd2;
  localparam logic [3:0] S_HDR3 = 4'd3;
  localparam logic [3:0] S_CMD  = 4'd4;
  localparam logic [3:0] S_FILL = 4'd5;
  localparam logic [3:0] S_LIT  = 4'd6;
  localparam logic [3:0] S_EMIT = 4'd7;
  localparam logic [3:0] S_SKIP = 4'd8;

  logic [3:0] state, state_next;
  logic [3:0] ret_phase, ret_phase_next;
  logic       accept;

  assign byte_ready = state inside {[S_HDR0:S_LIT]};
  assign accept     = byte_valid && byte_ready;

  always_comb begin
    state_next     = state;
    ret_phase_next = ret_phase;
    cmd            = '{op: OP_NONE, restart: 1'b0, emit_step: 1'b0, skip_step: 1'b0};
    if (accept) begin
      cmd.restart = last_byte;
      case (state)
        S_HDR0: begin
          cmd.op     = OP_HDR0;
          state_next = S_HDR1;
        end
        S_HDR1: begin
          cmd.op     = OP_HDR1;
          state_next = S_HDR2;
        end
        S_HDR2: begin
          cmd.op     = OP_HDR2;
          state_next = S_HDR3;
        end
        S_HDR3: begin
          cmd.op     = OP_HDR3;
          state_next = S_CMD;
        end
        S_CMD: begin
          if (!status.cmd_ok) begin
            cmd.op     = OP_FINISH;
            state_next = S_CMD;
          end else begin
            case (data_byte[7:6])
              TYPE_FILL: begin
                if (last_byte) begin
                  cmd.op     = OP_FILL_ZERO;
                  state_next = S_EMIT;
                end else begin
                  cmd.op     = OP_FILL_ARM;
                  state_next = S_FILL;
                end
              end
              TYPE_SKIP_LIT: begin
                cmd.op         = OP_SKIP_LIT;
                state_next     = S_SKIP;
                ret_phase_next = S_LIT;
              end
              TYPE_EXT: begin
                if (data_byte[SKIP_FLAG_BIT]) begin
                  cmd.op         = OP_SKIP;
                  state_next     = S_SKIP;
                  ret_phase_next = S_CMD;
                end else begin
                  cmd.op     = OP_LIT_ARM;
                  state_next = S_LIT;
                end
              end
              default: begin
                cmd.op     = OP_LIT_ARM;
                state_next = S_LIT;
              end
            endcase
          end
        end
        S_FILL: begin
          cmd.op         = OP_FILL_RUN;
          state_next     = S_EMIT;
          ret_phase_next = S_CMD;
        end
        S_LIT: begin
          cmd.op         = OP_LIT_PIXEL;
          state_next     = S_EMIT;
          ret_phase_next = status.run_last ? S_CMD : S_LIT;
        end
        default: state_next = S_HDR0;
      endcase
      // The final byte still runs its loop, then the decoder waits for a header.
      if (last_byte) begin
        ret_phase_next = S_HDR0;
        if (!(state_next == S_EMIT || state_next == S_SKIP)) begin
          state_next = S_HDR0;
        end
      end
    end else begin
      case (state)
        S_HDR0, S_HDR1, S_HDR2, S_HDR3, S_CMD, S_FILL, S_LIT: begin
        end
        S_EMIT: begin
          cmd.emit_step = status.slot_free;
          if (status.slot_free && status.cnt_last) begin
            state_next = ret_phase;
          end
        end
        S_SKIP: begin
          cmd.skip_step = 1'b1;
          if (status.cnt_last) begin
            state_next = ret_phase;
          end
        end
        default: state_next = S_HDR0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_HDR0;
      ret_phase <= S_HDR0;
    end else begin
      state     <= state_next;
      ret_phase <= ret_phase_next;
    end
  end

endmodule

`default_nettype wire

@@ design/srd_datapath.sv @@
// ---------------------------------------------------------------------------
// srd_datapath
// Image geometry, pixel position tracking, run counters and the output
// register of the sprite RLE decoder.
// ---------------------------------------------------------------------------
`default_nettype none

module srd_datapath import srd_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [DATA_W-1:0]      data_byte,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  output logic                   pixel_valid,
  input  logic                   pixel_ready,
  output logic [ADDR_W-1:0]      pixel_address,
  output logic [DATA_W-1:0]      pixel_value,
  output logic                   last_of_run
);

  logic [DIM_W-1:0]  default_width, default_height;
  logic [DIM_W-1:0]  image_width, image_height;
  logic [DIM_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  logic [ADDR_W-1:0] row_base;   // row_count * image_width, modulo the address space
  logic [CNT_W-1:0]  run_remaining;
  logic [CNT_W-1:0]  pending_fill_count;
  logic              stream_finished;
  logic [CNT_W-1:0]  step_count;
  logic [DATA_W-1:0] pixel_data;

  logic [CNT_W-1:0]  count;
  logic [DIM_W:0]    col_inc;
  logic              wrap, row_ok, row_move;
  logic [DIM_W-1:0]  column_next;
  logic [ROW_W-1:0]  row_next;
  logic [ADDR_W-1:0] row_base_next;
  logic              writable, next_writable;
  logic              advance, load_out;
  logic [DIM_W-1:0]  height_cand;

  assign count       = run_count(data_byte);
  assign col_inc     = {1'b0, column_count} + (DIM_W+1)'(1);
  assign wrap        = col_inc >= {1'b0, image_width};
  assign row_ok      = row_count != ROW_SATURATED;
  assign row_move    = wrap && row_ok;
  assign column_next = wrap ? '0 : col_inc[DIM_W-1:0];
  assign row_next    = row_move ? row_count + ROW_W'(1) : row_count;
  assign row_base_next = row_move ?
                         row_base + {{(ADDR_W-DIM_W){1'b0}}, image_width} : row_base;

  assign writable = ({{(DIM_W-ROW_W){1'b0}}, row_count} < image_height) &&
                    (column_count < image_width) && row_ok;
  assign next_writable = ({{(DIM_W-ROW_W){1'b0}}, row_next} < image_height) &&
                         (column_next < image_width) && (row_next != ROW_SATURATED);

  assign advance  = cmd.emit_step || cmd.skip_step;
  assign load_out = cmd.emit_step && writable;

  assign height_cand = {data_byte, image_height[DATA_W-1:0]};

  assign status.cmd_ok = !stream_finished &&
                         ({{(DIM_W-ROW_W){1'b0}}, row_count} < image_height) &&
                         (row_count < ROW_W'(MAX_ROWS));
  assign status.cnt_last  = step_count == CNT_W'(1);
  assign status.run_last  = run_remaining == CNT_W'(1);
  assign status.slot_free = !pixel_valid || pixel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_width      <= DEFAULT_WIDTH_RESET;
      default_height     <= DEFAULT_HEIGHT_RESET;
      image_width        <= '0;
      image_height       <= '0;
      column_count       <= '0;
      row_count          <= '0;
      row_base           <= '0;
      run_remaining      <= '0;
      pending_fill_count <= '0;
      stream_finished    <= 1'b0;
      pixel_valid        <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_DEFAULT_WIDTH:  default_width  <= cfg_data;
          REG_DEFAULT_HEIGHT: default_height <= cfg_data;
          default: ;
        endcase
      end

      if (advance) begin
        column_count <= column_next;
        row_count    <= row_next;
        row_base     <= row_base_next;
      end

      case (cmd.op)
        OP_HDR0: image_width <= {{(DIM_W-DATA_W){1'b0}}, data_byte};
        OP_HDR1: image_width[DIM_W-1:DATA_W] <= data_byte;
        OP_HDR2: image_height <= {{(DIM_W-DATA_W){1'b0}}, data_byte};
        OP_HDR3: begin
          if (image_width == '0 || height_cand == '0) begin
            image_width  <= default_width;
            image_height <= default_height;
          end else begin
            image_height <= height_cand;
          end
          column_count <= '0;
          row_count    <= '0;
          row_base     <= '0;
        end
        default: ;
      endcase

      // The final byte of the stream drops any run in progress.
      if (cmd.restart) begin
        stream_finished    <= 1'b0;
        run_remaining      <= '0;
        pending_fill_count <= '0;
      end else begin
        case (cmd.op)
          OP_HDR3:     stream_finished    <= 1'b0;
          OP_FINISH:   stream_finished    <= 1'b1;
          OP_FILL_ARM: pending_fill_count <= count;
          OP_FILL_RUN: pending_fill_count <= '0;
          OP_SKIP_LIT, OP_LIT_ARM: run_remaining <= count;
          OP_LIT_PIXEL: begin
            if (run_remaining != '0) begin
              run_remaining <= run_remaining - CNT_W'(1);
            end
          end
          default: ;
        endcase
      end

      if (load_out) begin
        pixel_valid <= 1'b1;
      end else if (pixel_ready) begin
        pixel_valid <= 1'b0;
      end
    end
  end

  // Loop counter, pixel byte of the loop and output payload.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_FILL_ZERO: begin
        step_count <= count;
        pixel_data <= '0;
      end
      OP_FILL_RUN: begin
        step_count <= pending_fill_count;
        pixel_data <= data_byte;
      end
      OP_SKIP_LIT, OP_SKIP: step_count <= count;
      OP_LIT_PIXEL: begin
        step_count <= CNT_W'(1);
        pixel_data <= data_byte;
      end
      default: begin
        if (advance) begin
          step_count <= step_count - CNT_W'(1);
        end
      end
    endcase

    if (load_out) begin
      pixel_address <= row_base + {{(ADDR_W-DIM_W){1'b0}}, column_count};
      pixel_value   <= pixel_data;
      // Written pixels form a prefix of the loop, so the last write is the
      // final pixel or the one whose successor falls outside the image.
      last_of_run   <= status.cnt_last || !next_writable;
    end
  end

endmodule

`default_nettype wire

@@ design/sprite_rle_decoder.sv @@
// ---------------------------------------------------------------------------
// sprite_rle_decoder
// Byte-serial run-length image decoder that turns a compressed stream into
// (linear address, value) pixel writes.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Payload
//   stream    in         byte_valid / byte_ready    data_byte, last_byte
//   pixels    out        pixel_valid / pixel_ready  pixel_address, pixel_value,
//                                                   last_of_run
//   config    in         cfg_write (no wait)        cfg_index, cfg_data
//
// Header bytes, command bytes that only arm a run, and discarded bytes are
// taken with no loop. A fill data byte starts a write loop over the pixels
// of its run, a literal byte writes one pixel, and a skip command starts a
// loop over the skipped pixels; the stream input is not ready while a loop
// runs. The pixel write loop goes one pixel per cycle; a stalled output
// register holds that loop. Reset needs no clearing pass.
// The output register lets the next item be accepted while the last pixel of
// the previous run still waits to be taken.
//
`default_nettype none

module sprite_rle_decoder import srd_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port.
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Compressed stream, one byte per item.
  input  logic                   byte_valid,
  output logic                   byte_ready,
  input  logic [DATA_W-1:0]      data_byte,
  input  logic                   last_byte,
  // Pixel writes, one per item.
  output logic                   pixel_valid,
  input  logic                   pixel_ready,
  output logic [ADDR_W-1:0]      pixel_address,
  output logic [DATA_W-1:0]      pixel_value,
  output logic                   last_of_run
);

  // The controller holds the decode phase and sequences the run loops; the
  // datapath holds geometry, position and counters and reports status back.
  dp_cmd_t    cmd;
  dp_status_t status;

  srd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .cmd        (cmd),
    .status     (status)
  );

  // The linear address is kept as a running row base plus the column, so no
  // multiplier is needed: each row wrap adds the width once.
  srd_datapath #(
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .data_byte     (data_byte),
    .cmd           (cmd),
    .status        (status),
    .pixel_valid   (pixel_valid),
    .pixel_ready   (pixel_ready),
    .pixel_address (pixel_address),
    .pixel_value   (pixel_value),
    .last_of_run   (last_of_run)
  );

endmodule

`default_nettype wire

@@ design/srd_checker.sv @@
// ---------------------------------------------------------------------------
// srd_checker
// Port-level checks of the sprite RLE decoder, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sprite_rle_decoder_assert.svh"

module srd_checker (
  input logic clk,
  input logic rst,
  input logic byte_ready,
  input logic pixel_valid,
  input logic pixel_ready
);

  // A pixel that is not taken stays offered.
  `SRD_ASSERT_NEXT(a_pixel_held, pixel_valid && !pixel_ready, pixel_valid)

  // Reset empties the output register.
  `SRD_ASSERT_AFTER_RESET(a_reset_empties_output, !pixel_valid)

  // A new pixel comes only from a write loop, while no item is accepted.
  `SRD_ASSERT_IMPLY(a_fresh_pixel_from_loop,
                    pixel_valid && !$past(pixel_valid && !pixel_ready),
                    !$past(byte_ready))

endmodule

bind sprite_rle_decoder srd_checker u_checker (.*);

`default_nettype wire

@@ bench/srd_pixel_tracker.sv @@
// ----------------------------------------------------------------------------
// Pixel write tracker for the sprite RLE decoder
// Watches the configuration port and both handshake channels. It decodes every
// accepted stream item on its own copy of the decoder state and matches each
// accepted pixel write against the oldest pixel still owed.
// ----------------------------------------------------------------------------
module srd_pixel_tracker import srd_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   byte_valid,
  input  logic                   byte_ready,
  input  logic [DATA_W-1:0]      data_byte,
  input  logic                   last_byte,
  input  logic                   pixel_valid,
  input  logic                   pixel_ready,
  input  logic [ADDR_W-1:0]      pixel_address,
  input  logic [DATA_W-1:0]      pixel_value,
  input  logic                   last_of_run,
  output int                     pixel_errors,
  output int                     pixels_owed
);

  typedef enum logic [2:0] {
    HDR_W_LO, HDR_W_HI, HDR_H_LO, HDR_H_HI, TAKE_CMD, FILL_DATA, LIT_DATA
  } stage_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] value;
    logic              last;
  } pixel_t;

  pixel_t owed_pixels[$];
  pixel_t burst[16];
  int     burst_len;
  int     error_total;

  logic [DIM_W-1:0]  dflt_w, dflt_h;
  stage_t            stage;
  logic [DIM_W-1:0]  img_w, img_h, col;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] lin;
  logic [CNT_W-1:0]  run_left, fill_left;
  logic              image_done;

  function automatic void back_to_header();
    stage      = HDR_W_LO;
    image_done = 1'b0;
    run_left   = '0;
    fill_left  = '0;
  endfunction

  // One pixel step: the column wraps at the width and the row saturates.
  function automatic void move_on();
    if (int'(col) + 1 >= int'(img_w)) begin
      col = '0;
      if (row != ROW_SATURATED) row = row + 1'b1;
    end else begin
      col = col + 1'b1;
    end
    lin = ADDR_W'(int'(row) * int'(img_w) + int'(col));
  endfunction

  function automatic void put_pixel(input logic [DATA_W-1:0] v);
    if (row < img_h && col < img_w && row != ROW_SATURATED && burst_len < 16) begin
      burst[burst_len] = '{addr: lin, value: v, last: 1'b0};
      burst_len++;
    end
    move_on();
  endfunction

  // Decodes one stream item and queues the pixel writes it must produce.
  function automatic void decode_byte(input logic [DATA_W-1:0] b, input logic fin);
    int cnt;
    int i;
    burst_len = 0;
    cnt = int'(b[5:2]) + 1;
    case (stage)
      HDR_W_LO: begin
        img_w = {8'h00, b};
        stage = HDR_W_HI;
      end
      HDR_W_HI: begin
        img_w[15:8] = b;
        stage = HDR_H_LO;
      end
      HDR_H_LO: begin
        img_h = {8'h00, b};
        stage = HDR_H_HI;
      end
      HDR_H_HI: begin
        img_h[15:8] = b;
        if (img_w == '0 || img_h == '0) begin
          img_w = dflt_w;
          img_h = dflt_h;
        end
        col        = '0;
        row        = '0;
        lin        = '0;
        image_done = 1'b0;
        stage      = TAKE_CMD;
      end
      FILL_DATA: begin
        for (i = 0; i < int'(fill_left); i++) put_pixel(b);
        fill_left = '0;
        stage     = TAKE_CMD;
      end
      LIT_DATA: begin
        put_pixel(b);
        if (run_left != '0) run_left = run_left - 1'b1;
        if (run_left == '0) stage = TAKE_CMD;
      end
      default: begin
        // Once the image is complete every further byte is thrown away.
        if (image_done || row >= img_h || row >= MAX_ROWS) begin
          image_done = 1'b1;
        end else if (b[7:6] == TYPE_FILL) begin
          if (fin) begin
            for (i = 0; i < cnt; i++) put_pixel('0);
          end else begin
            fill_left = CNT_W'(cnt);
            stage     = FILL_DATA;
          end
        end else if (b[7:6] == TYPE_SKIP_LIT) begin
          repeat (cnt) move_on();
          run_left = CNT_W'(cnt);
          stage    = LIT_DATA;
        end else if (b[7:6] == TYPE_EXT && b[SKIP_FLAG_BIT]) begin
          repeat (cnt) move_on();
        end else begin
          run_left = CNT_W'(cnt);
          stage    = LIT_DATA;
        end
      end
    endcase
    if (fin) back_to_header();
    if (burst_len > 0) burst[burst_len-1].last = 1'b1;
    for (i = 0; i < burst_len; i++) owed_pixels.push_back(burst[i]);
  endfunction

  always @(posedge clk) begin : watch
    pixel_t want;
    if (rst) begin
      dflt_w = DEFAULT_WIDTH_RESET;
      dflt_h = DEFAULT_HEIGHT_RESET;
      img_w  = '0;
      img_h  = '0;
      col    = '0;
      row    = '0;
      lin    = '0;
      back_to_header();
      owed_pixels.delete();
      error_total = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_DEFAULT_WIDTH) dflt_w = cfg_data;
        else if (cfg_index == REG_DEFAULT_HEIGHT) dflt_h = cfg_data;
      end
      if (byte_valid && byte_ready) decode_byte(data_byte, last_byte);
      if (pixel_valid && pixel_ready) begin
        if (owed_pixels.size() == 0) begin
          error_total++;
          $display("%0t: unexpected pixel write: expected none, got addr=%06h value=%02h last=%0b",
                   $time, pixel_address, pixel_value, last_of_run);
        end else begin
          want = owed_pixels.pop_front();
          if (want.addr != pixel_address || want.value != pixel_value ||
              want.last != last_of_run) begin
            error_total++;
            $display("%0t: pixel mismatch: expected addr=%06h value=%02h last=%0b, %s",
                     $time, want.addr, want.value, want.last,
                     $sformatf("got addr=%06h value=%02h last=%0b",
                               pixel_address, pixel_value, last_of_run));
          end
        end
      end
    end
    pixel_errors <= error_total;
    pixels_owed  <= owed_pixels.size();
  end

endmodule

@@ bench/sprite_rle_decoder_test.sv @@
// ----------------------------------------------------------------------------
// Sprite RLE decoder regression
// Drives compressed image streams into the decoder under random idling and a
// long output stall, across several default image sizes, and lets the pixel
// tracker check every pixel write. Prints one verdict at the end.
// ----------------------------------------------------------------------------
module sprite_rle_decoder_test;
  import srd_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   byte_valid = 1'b0;
  logic                   byte_ready;
  logic [DATA_W-1:0]      data_byte = '0;
  logic                   last_byte = 1'b0;
  logic                   pixel_valid;
  logic                   pixel_ready = 1'b0;
  logic [ADDR_W-1:0]      pixel_address;
  logic [DATA_W-1:0]      pixel_value;
  logic                   last_of_run;
  int                     pixel_errors;
  int                     pixels_owed;

  // Idling switches for the stream side and the pixel side, and a request for
  // one long pixel-side stall that the sink process serves on its own.
  logic src_idle = 1'b1;
  logic sink_idle = 1'b1;
  logic hold_request = 1'b0;
  int   bytes_sent = 0;

  sprite_rle_decoder dut (.*);

  srd_pixel_tracker tracker (.*);

  always #2 clk = ~clk;

  // Hard stop in case the decoder hangs somewhere.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Pixel sink. Ready moves only on falling edges. Bursts of stalled cycles
  // of random length come at random while idling is on; a hold request keeps
  // ready low in one long stall so the output backs up into the stream input.
  always begin
    @(negedge clk);
    if (hold_request) begin
      pixel_ready <= 1'b0;
      repeat (300) @(negedge clk);
      hold_request = 1'b0;
    end else if (sink_idle && $urandom_range(0, 4) == 0) begin
      pixel_ready <= 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk);
    end else begin
      pixel_ready <= 1'b1;
    end
  end

  // Offers one stream item and holds it until the decoder takes it. Valid is
  // only dropped when a gap is inserted, and raised again at a later edge.
  task automatic send_byte(input logic [DATA_W-1:0] b, input logic fin);
    int gap;
    gap = (src_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    @(negedge clk);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid <= 1'b1;
    data_byte  <= b;
    last_byte  <= fin;
    do @(posedge clk); while (!byte_ready);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Stops offering items, waits for every owed pixel, then gives the decoder
  // time to finish a skip or a discard that produces no pixel at all.
  task automatic drain();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (pixels_owed != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // One image: a header, a handful of well-formed commands with random
  // content, and a closing byte that carries last. Now and then the stream is
  // cut short anywhere instead, including inside the header or a run.
  task automatic send_image();
    logic [DATA_W-1:0] stream_q[$];
    logic [DATA_W-1:0] cmd;
    logic [DIM_W-1:0]  w, h;
    int                kind, cut, i;
    kind = $urandom_range(0, 19);
    if (kind < 12) begin
      // Small images complete quickly, so the discard path gets exercised.
      w = DIM_W'($urandom_range(1, 6));
      h = DIM_W'($urandom_range(1, 5));
    end else if (kind < 15) begin
      // A zero dimension selects the configured defaults.
      w = $urandom_range(0, 1) ? '0 : DIM_W'($urandom_range(1, 9));
      h = (w == '0) ? DIM_W'($urandom_range(0, 3)) : '0;
    end else if (kind < 18) begin
      w = DIM_W'($urandom_range(1, 65535));
      h = DIM_W'($urandom_range(1, 3));
    end else begin
      w = DIM_W'($urandom);
      h = DIM_W'($urandom);
    end
    stream_q = {w[7:0], w[15:8], h[7:0], h[15:8]};
    repeat ($urandom_range(1, 8)) begin
      cmd = DATA_W'($urandom);
      // Half of the commands get short runs to keep the images moving.
      if ($urandom_range(0, 1) == 0) cmd[5:4] = 2'b00;
      stream_q.push_back(cmd);
      if (cmd[7:6] == TYPE_FILL) begin
        stream_q.push_back(DATA_W'($urandom));
      end else if (!(cmd[7:6] == TYPE_EXT && cmd[SKIP_FLAG_BIT])) begin
        repeat (int'(cmd[5:2]) + 1) stream_q.push_back(DATA_W'($urandom));
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, stream_q.size());
    end else begin
      stream_q.push_back(DATA_W'($urandom));
      cut = stream_q.size();
    end
    for (i = 0; i < cut; i++) send_byte(stream_q[i], i == cut - 1);
  endtask

  // A few fully random bytes; last shows up now and then.
  task automatic send_noise();
    repeat ($urandom_range(1, 6)) send_byte(DATA_W'($urandom), $urandom_range(0, 7) == 0);
  endtask

  // Random streams until the phase has pushed its share of items, then one
  // byte with last so the next phase starts on a header.
  task automatic run_phase(input int share);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < share) begin
      if ($urandom_range(0, 6) == 0) send_noise();
      else send_image();
    end
    send_byte(DATA_W'($urandom), 1'b1);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed streams under the reset defaults of 320 by 200.
    // A 4 by 3 image filled with a 16 pixel run of 0xFF: the last four pixels
    // fall past the image, so the next command is discarded up to the last byte.
    send_byte(8'h04, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h03, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h3C, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h81, 1'b0); send_byte(8'hA5, 1'b1);
    // Zero width in the header: the defaults apply. Then a literal run, a skip
    // followed by literals, a pure skip, an extended literal, and a fill code
    // that ends the stream and so fills with zero.
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h05, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h44, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0); send_byte(8'h5A, 1'b0);
    send_byte(8'hFC, 1'b0);
    send_byte(8'hC0, 1'b0); send_byte(8'h11, 1'b0);
    send_byte(8'h0C, 1'b1);
    // The stream ends inside the header.
    send_byte(8'h07, 1'b1);
    // A 1 by 1 image whose literal run is cut off by the last byte.
    send_byte(8'h01, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h44, 1'b0); send_byte(8'h99, 1'b1);
    drain();

    // Largest defaults, with one long pixel stall while the sender keeps going.
    write_reg(REG_DEFAULT_WIDTH, 16'hFFFF);
    write_reg(REG_DEFAULT_HEIGHT, 16'hFFFF);
    hold_request = 1'b1;
    run_phase(28);
    drain();

    // Smallest legal defaults: a single pixel image.
    write_reg(REG_DEFAULT_WIDTH, 16'd1);
    write_reg(REG_DEFAULT_HEIGHT, 16'd1);
    run_phase(28);
    drain();

    // A zero default width: the row moves on every pixel and nothing is written.
    write_reg(REG_DEFAULT_WIDTH, 16'd0);
    write_reg(REG_DEFAULT_HEIGHT, 16'd7);
    run_phase(28);
    drain();

    // Small random defaults, and no idling on either side to the end.
    write_reg(REG_DEFAULT_WIDTH, CFG_DATA_W'($urandom_range(1, 40)));
    write_reg(REG_DEFAULT_HEIGHT, CFG_DATA_W'($urandom_range(1, 12)));
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    run_phase(28);
    drain();

    if (pixel_errors == 0 && pixels_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sprite_rle_decoder.f @@
+incdir+design
design/srd_pkg.sv
design/srd_ctrl.sv
design/srd_datapath.sv
design/sprite_rle_decoder.sv
design/srd_checker.sv
bench/srd_pixel_tracker.sv
bench/sprite_rle_decoder_test.sv
